@@ hw/rtl/ufd_pkg.sv @@
package ufd_pkg;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 32;
  localparam int OUT_IDX_W = 6;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FOURTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_MARKER   = 3'd4;

  // Reset values: "s", 0xFF, 0x00, 0xAA, "e"
  localparam logic [BYTE_W-1:0] RST_HEADER_FIRST  = 8'h73;
  localparam logic [BYTE_W-1:0] RST_HEADER_SECOND = 8'hFF;
  localparam logic [BYTE_W-1:0] RST_HEADER_THIRD  = 8'h00;
  localparam logic [BYTE_W-1:0] RST_HEADER_FOURTH = 8'hAA;
  localparam logic [BYTE_W-1:0] RST_STOP_MARKER   = 8'h65;

  typedef struct packed {
    logic hdr_hit;   // window plus current byte equal the header
    logic stop_hit;  // current byte equals the stop marker
  } match_t;

endpackage

@@ hw/rtl/ufd_ifs.sv @@
interface ufd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [ufd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufd_word_if;
  logic                         valid;
  logic                         ready;
  logic [ufd_pkg::OUT_IDX_W-1:0] word_index;
  logic [ufd_pkg::WORD_W-1:0]    payload_word;
  logic                         last_word;

  modport source (output valid, output word_index, output payload_word, output last_word,
                  input ready);
  modport sink   (input valid, input word_index, input payload_word, input last_word,
                  output ready);
endinterface

interface ufd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ufd_pkg::CFG_IDX_W-1:0] reg_index;
  logic [ufd_pkg::BYTE_W-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ hw/rtl/uart_frame_deframer.sv @@
// Channel  Role    Payload                                   Request taken when
// -------  ------  ----------------------------------------  ------------------
// rx       sink    rx_byte[7:0]                              rx.valid & rx.ready
// words    source  word_index[5:0] payload_word[31:0]        words.valid & words.ready
//                  last_word
// cfg      sink    reg_index[2:0] wdata[7:0]                 cfg.valid & cfg.ready
//
// Hunting and capture take one byte request per cycle; a payload byte goes
// straight into one byte lane of the word memory.
// After a good stop byte the block drains WORDS words, one per cycle when the
// sink keeps ready high, limited by the single read port of the word memory;
// rx is not ready during the drain.
// Synchronous reset returns to hunting with a cleared window and default
// registers; the payload memory is not cleared. cfg is always ready.
// The word output register holds while words.ready is low; the next memory
// read is issued only when that register is empty or being taken.
module uart_frame_deframer #(
  parameter int WORDS = 8
) (
  input  logic         clk,
  input  logic         rst,
  ufd_byte_if.sink     rx,
  ufd_word_if.source   words,
  ufd_cfg_if.sink      cfg
);

  localparam int PAYLOAD_BYTES = 4 * WORDS;
  localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int ADDR_W        = (WORDS > 1) ? $clog2(WORDS) : 1;

  typedef enum logic [1:0] {
    S_HUNT,
    S_CAPT,
    S_DRAIN
  } state_t;

  state_t                     state;
  logic [CNT_W-1:0]           byte_cnt;
  logic [ADDR_W-1:0]          rd_idx;
  logic                       out_valid;
  logic [ufd_pkg::OUT_IDX_W-1:0] out_idx;
  logic                       out_last;
  logic [ufd_pkg::WORD_W-1:0] rd_data;

  // word memory, one byte lane written per payload byte
  logic [ufd_pkg::WORD_W-1:0] mem [WORDS];

  ufd_pkg::match_t            match;

  logic rx_take;
  logic cnt_full;
  logic wr_en;
  logic rd_go;
  logic rd_last;

  assign rx.ready = (state != S_DRAIN);
  assign rx_take  = rx.valid && rx.ready;
  assign cnt_full = (byte_cnt == CNT_W'(PAYLOAD_BYTES));
  assign wr_en    = rx_take && (state == S_CAPT) && !cnt_full;
  // read only into an empty (or emptying) output register
  assign rd_go    = (state == S_DRAIN) && (!out_valid || words.ready);
  assign rd_last  = (rd_idx == ADDR_W'(WORDS - 1));

  ufd_hunt u_hunt (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .shift_en (rx_take && (state == S_HUNT)),
    .rx_byte  (rx.rx_byte),
    .match    (match)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[byte_cnt[ADDR_W+1:2]][8*byte_cnt[1:0] +: 8] <= rx.rx_byte;
    end
    if (rd_go) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_HUNT;
      byte_cnt  <= '0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
      out_idx   <= '0;
      out_last  <= 1'b0;
    end else begin
      // a new read refills the output register, else a taken word empties it
      if (rd_go) begin
        out_valid <= 1'b1;
      end else if (words.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_HUNT: begin
          if (rx_take && match.hdr_hit) begin
            state    <= S_CAPT;
            byte_cnt <= '0;
          end
        end
        S_CAPT: begin
          if (rx_take) begin
            if (cnt_full) begin
              // frame end: good stop byte drains, anything else drops the frame
              byte_cnt <= '0;
              rd_idx   <= '0;
              state    <= match.stop_hit ? S_DRAIN : S_HUNT;
            end else begin
              byte_cnt <= byte_cnt + 1'b1;
            end
          end
        end
        S_DRAIN: begin
          if (rd_go) begin
            out_idx   <= ufd_pkg::OUT_IDX_W'(rd_idx);
            out_last  <= rd_last;
            if (rd_last) begin
              rd_idx <= '0;
              state  <= S_HUNT;
            end else begin
              rd_idx <= rd_idx + 1'b1;
            end
          end
        end
        default: state <= S_HUNT;
      endcase
    end
  end

  assign words.valid        = out_valid;
  assign words.word_index   = out_idx;
  assign words.payload_word = rd_data;
  assign words.last_word    = out_last;

`ifndef SYNTHESIS
  // the last word is always read before the block leaves the drain
  a_last_after_drain: assert property (@(posedge clk) disable iff (rst)
    (rd_go && rd_last) |=> (state == S_HUNT))
    else $error("drain did not end after the last read");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    words.valid |-> (words.last_word == (words.word_index == ufd_pkg::OUT_IDX_W'(WORDS - 1))))
    else $error("last flag does not match word index");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CAPT) |-> (byte_cnt <= CNT_W'(PAYLOAD_BYTES)))
    else $error("payload count overran");

  a_drain_entry: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DRAIN) && ($past(state) != S_DRAIN)) |->
      $past(rx_take && cnt_full && match.stop_hit))
    else $error("drain started without a good stop byte");

  a_no_stale_out: assert property (@(posedge clk) disable iff (rst)
    (words.valid && !words.ready) |=> words.valid && $stable(words.word_index))
    else $error("stalled word lost");
`endif

endmodule

@@ hw/rtl/ufd_hunt.sv @@
// Header/stop registers, three-byte history window and the byte compares.
module ufd_hunt (
  input  logic                       clk,
  input  logic                       rst,
  ufd_cfg_if.sink                    cfg,
  input  logic                       shift_en,
  input  logic [ufd_pkg::BYTE_W-1:0] rx_byte,
  output ufd_pkg::match_t            match
);

  logic [ufd_pkg::BYTE_W-1:0]   hdr_first;
  logic [ufd_pkg::BYTE_W-1:0]   hdr_second;
  logic [ufd_pkg::BYTE_W-1:0]   hdr_third;
  logic [ufd_pkg::BYTE_W-1:0]   hdr_fourth;
  logic [ufd_pkg::BYTE_W-1:0]   stop_marker;
  logic [3*ufd_pkg::BYTE_W-1:0] recent;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_first   <= ufd_pkg::RST_HEADER_FIRST;
      hdr_second  <= ufd_pkg::RST_HEADER_SECOND;
      hdr_third   <= ufd_pkg::RST_HEADER_THIRD;
      hdr_fourth  <= ufd_pkg::RST_HEADER_FOURTH;
      stop_marker <= ufd_pkg::RST_STOP_MARKER;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        ufd_pkg::REG_HEADER_FIRST:  hdr_first   <= cfg.wdata;
        ufd_pkg::REG_HEADER_SECOND: hdr_second  <= cfg.wdata;
        ufd_pkg::REG_HEADER_THIRD:  hdr_third   <= cfg.wdata;
        ufd_pkg::REG_HEADER_FOURTH: hdr_fourth  <= cfg.wdata;
        ufd_pkg::REG_STOP_MARKER:   stop_marker <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // oldest byte in the top lane
  always_ff @(posedge clk) begin
    if (rst) begin
      recent <= '0;
    end else if (shift_en) begin
      recent <= {recent[2*ufd_pkg::BYTE_W-1:0], rx_byte};
    end
  end

  always_comb begin
    match.hdr_hit  = (recent == {hdr_first, hdr_second, hdr_third}) && (rx_byte == hdr_fourth);
    match.stop_hit = (rx_byte == stop_marker);
  end

endmodule
